// File: design/sbpr_pkg.sv
// shared constants, types and helpers for the spectrum bar peak renderer
package sbpr_pkg;

  localparam int unsigned NumBands     = 16;
  localparam int unsigned BandIdxW     = 4;
  localparam int unsigned BandWidthLog = 2;
  localparam int unsigned PanelSize    = 64;
  localparam int unsigned CoordW       = 6;
  localparam int unsigned LevelW       = 8;
  localparam int unsigned FillW        = 8;
  localparam int unsigned HeightW      = 6;
  localparam int unsigned PixelW       = 16;
  localparam int unsigned RgbW         = 24;
  localparam int unsigned ApbAddrW     = 3;
  localparam int unsigned ApbDataW     = 32;

  localparam logic [HeightW-1:0] LevelMax     = 6'd60;
  localparam logic [CoordW-1:0]  BarBaseRow   = 6'd60;
  localparam logic [CoordW-1:0]  ProgRowA     = 6'(PanelSize - 2);
  localparam logic [CoordW-1:0]  ProgRowB     = 6'(PanelSize - 1);
  localparam logic [PixelW-1:0]  White565     = 16'hFFFF;
  localparam logic [PixelW-1:0]  Black565     = 16'h0000;
  localparam logic [RgbW-1:0]    BarRgbReset  = 24'hFF7800;

  // register index, taken from paddr above the word offset
  localparam logic RegBarRgb = 1'b0;

  typedef enum logic {
    REQ_UPDATE = 1'b0,
    REQ_QUERY  = 1'b1
  } req_e;

  typedef struct packed {
    req_e                     req;
    logic [BandIdxW-1:0]      addr;
    logic [LevelW-1:0]        level;
    logic [CoordW-1:0]        x;
    logic [CoordW-1:0]        y;
    logic signed [FillW-1:0]  fill;
  } item_t;

  function automatic logic [PixelW-1:0] to_rgb565(input logic [RgbW-1:0] rgb);
    return {rgb[23:19], rgb[15:10], rgb[7:3]};
  endfunction

endpackage

// File: design/spectrum_bar_peak_renderer.sv
// top level of the spectrum bar peak renderer: band store, pixel logic, apb register
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  item in | start_i, busy_o, req_type_i .. fill_i      | in
//  result  | done_o, pixel_o, band_height_o, band_peak_o| out
//  config  | psel .. pwdata, prdata, pready              | apb
//
//  one item per clock; busy_o stays low
//  each result shows on done_o once its start has passed the input reg and the result reg
//  band height and peak live in flops, read at one address and written per update
//  reset clears heights, peaks and the pipeline and loads the default bar colour
//  the receiver cannot stall, so nothing ever backs up
module spectrum_bar_peak_renderer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic                                  req_type_i,
  input  logic [sbpr_pkg::BandIdxW-1:0]         band_i,
  input  logic [sbpr_pkg::LevelW-1:0]           level_i,
  input  logic [sbpr_pkg::CoordW-1:0]           x_i,
  input  logic [sbpr_pkg::CoordW-1:0]           y_i,
  input  logic signed [sbpr_pkg::FillW-1:0]     fill_i,
  output logic                                  done_o,
  output logic [sbpr_pkg::PixelW-1:0]           pixel_o,
  output logic [sbpr_pkg::HeightW-1:0]          band_height_o,
  output logic [sbpr_pkg::HeightW-1:0]          band_peak_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sbpr_pkg::ApbAddrW-1:0]         paddr,
  input  logic [sbpr_pkg::ApbDataW-1:0]         pwdata,
  output logic [sbpr_pkg::ApbDataW-1:0]         prdata,
  output logic                                  pready
);

  logic                              in_valid_q;
  sbpr_pkg::item_t                   in_q, in_d;
  logic [sbpr_pkg::RgbW-1:0]         bar_rgb_q;
  logic [sbpr_pkg::HeightW-1:0]      height_q [sbpr_pkg::NumBands];
  logic [sbpr_pkg::HeightW-1:0]      peak_q   [sbpr_pkg::NumBands];

  logic                              res_valid_q;
  logic [sbpr_pkg::PixelW-1:0]       pixel_q, pixel_d;
  logic [sbpr_pkg::HeightW-1:0]      res_h_q, res_h_d;
  logic [sbpr_pkg::HeightW-1:0]      res_p_q, res_p_d;

  logic                              accept;
  logic                              cfg_wr;
  logic [sbpr_pkg::HeightW-1:0]      rd_h, rd_p, upd_h, upd_p;
  logic                              is_prog, is_peak, is_bar;
  logic [sbpr_pkg::CoordW:0]         y_plus_p, y_plus_h;

  assign busy_o  = 1'b0;
  assign accept  = start_i && !busy_o;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready &&
                   (paddr[sbpr_pkg::ApbAddrW-1] == sbpr_pkg::RegBarRgb);
  assign prdata  = (paddr[sbpr_pkg::ApbAddrW-1] == sbpr_pkg::RegBarRgb) ?
                   {{(sbpr_pkg::ApbDataW-sbpr_pkg::RgbW){1'b0}}, bar_rgb_q} : '0;

  // query reads the band of column x, update the addressed band
  always_comb begin
    in_d.req   = sbpr_pkg::req_e'(req_type_i);
    in_d.addr  = req_type_i ? x_i[sbpr_pkg::CoordW-1:sbpr_pkg::BandWidthLog] : band_i;
    in_d.level = level_i;
    in_d.x     = x_i;
    in_d.y     = y_i;
    in_d.fill  = fill_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_rgb_q <= sbpr_pkg::BarRgbReset;
    end else if (cfg_wr) begin
      bar_rgb_q <= pwdata[sbpr_pkg::RgbW-1:0];
    end
  end

  assign rd_h = height_q[in_q.addr];
  assign rd_p = peak_q[in_q.addr];

  // saturate level, peak rises to height or decays by one
  always_comb begin
    upd_h = (in_q.level > {2'b00, sbpr_pkg::LevelMax}) ? sbpr_pkg::LevelMax
                                                       : in_q.level[sbpr_pkg::HeightW-1:0];
    if (upd_h > rd_p) begin
      upd_p = upd_h;
    end else if (rd_p != '0) begin
      upd_p = rd_p - 6'd1;
    end else begin
      upd_p = '0;
    end
  end

  always_comb begin
    y_plus_p = {1'b0, in_q.y} + {1'b0, rd_p};
    y_plus_h = {1'b0, in_q.y} + {1'b0, rd_h};
    is_prog  = ((in_q.y == sbpr_pkg::ProgRowA) || (in_q.y == sbpr_pkg::ProgRowB)) &&
               !in_q.fill[sbpr_pkg::FillW-1] &&
               ({2'b00, in_q.x} < in_q.fill);
    is_peak  = (rd_p != '0) && (y_plus_p == {1'b0, sbpr_pkg::BarBaseRow});
    is_bar   = (in_q.y <= sbpr_pkg::BarBaseRow) && (y_plus_h > {1'b0, sbpr_pkg::BarBaseRow});
  end

  always_comb begin
    case (in_q.req)
      sbpr_pkg::REQ_UPDATE: begin
        pixel_d = sbpr_pkg::Black565;
        res_h_d = upd_h;
        res_p_d = upd_p;
      end
      sbpr_pkg::REQ_QUERY: begin
        res_h_d = rd_h;
        res_p_d = rd_p;
        if (is_prog || is_peak) begin
          pixel_d = sbpr_pkg::White565;
        end else if (is_bar) begin
          pixel_d = sbpr_pkg::to_rgb565(bar_rgb_q);
        end else begin
          pixel_d = sbpr_pkg::Black565;
        end
      end
      default: begin
        pixel_d = sbpr_pkg::Black565;
        res_h_d = '0;
        res_p_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sbpr_pkg::NumBands; i++) begin
        height_q[i] <= '0;
        peak_q[i]   <= '0;
      end
    end else if (in_valid_q && (in_q.req == sbpr_pkg::REQ_UPDATE)) begin
      height_q[in_q.addr] <= upd_h;
      peak_q[in_q.addr]   <= upd_p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      pixel_q <= pixel_d;
      res_h_q <= res_h_d;
      res_p_q <= res_p_d;
    end
  end

  assign done_o        = res_valid_q;
  assign pixel_o       = pixel_q;
  assign band_height_o = res_h_q;
  assign band_peak_o   = res_p_q;

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("item accepted without a result two cycles later");

  a_no_stray_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_valid_q))
    else $error("result strobe without an item in the input register");

  a_height_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (band_height_o <= sbpr_pkg::LevelMax) && (band_peak_o <= sbpr_pkg::LevelMax))
    else $error("band height or peak above the saturation limit");

  a_update_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && (in_q.req == sbpr_pkg::REQ_UPDATE) |=> pixel_o == sbpr_pkg::Black565)
    else $error("update item gave a nonzero pixel");

endmodule

// File: tb/bar_pixel_checker.sv
// checker for the spectrum bar peak renderer: predicts each item's result and compares
`timescale 1ns / 100ps
module bar_pixel_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  sbpr_pkg::item_t                   item_i,
  input  logic                              done_i,
  input  logic [sbpr_pkg::PixelW-1:0]       pixel_i,
  input  logic [sbpr_pkg::HeightW-1:0]      band_height_i,
  input  logic [sbpr_pkg::HeightW-1:0]      band_peak_i,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [sbpr_pkg::ApbAddrW-1:0]     paddr_i,
  input  logic [sbpr_pkg::ApbDataW-1:0]     pwdata_i,
  input  logic [sbpr_pkg::ApbDataW-1:0]     prdata_i,
  input  logic                              pready_i,
  output int                                pending_o,
  output int                                fail_count_o
);

  typedef struct packed {
    logic [sbpr_pkg::PixelW-1:0]  pixel;
    logic [sbpr_pkg::HeightW-1:0] height;
    logic [sbpr_pkg::HeightW-1:0] peak;
  } bar_result_t;

  logic [sbpr_pkg::HeightW-1:0] height_mem [sbpr_pkg::NumBands];
  logic [sbpr_pkg::HeightW-1:0] peak_mem [sbpr_pkg::NumBands];
  logic [sbpr_pkg::RgbW-1:0]    bar_colour;
  bar_result_t                  result_q [$];

  initial fail_count_o = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic logic [sbpr_pkg::PixelW-1:0] colour_565(
    input logic [sbpr_pkg::RgbW-1:0] rgb
  );
    logic [sbpr_pkg::PixelW-1:0] r;
    logic [sbpr_pkg::PixelW-1:0] g;
    logic [sbpr_pkg::PixelW-1:0] b;
    r = sbpr_pkg::PixelW'(rgb[23:16] & 8'hF8) << 8;
    g = sbpr_pkg::PixelW'(rgb[15:8] & 8'hFC) << 3;
    b = sbpr_pkg::PixelW'(rgb[7:0]) >> 3;
    return r | g | b;
  endfunction

  task automatic render_item(input sbpr_pkg::item_t it, output bar_result_t res);
    int col;
    int h;
    int p;
    int row;
    int f;
    int base;
    res  = '0;
    base = int'(sbpr_pkg::BarBaseRow);
    if (it.req == sbpr_pkg::REQ_UPDATE) begin
      col = int'(it.addr);
      if (col < sbpr_pkg::NumBands) begin
        h = int'(it.level);
        if (h > int'(sbpr_pkg::LevelMax)) h = int'(sbpr_pkg::LevelMax);
        p = int'(peak_mem[col[sbpr_pkg::BandIdxW-1:0]]);
        if (h > p) p = h;
        else if (p > 0) p = p - 1;
        height_mem[col[sbpr_pkg::BandIdxW-1:0]] = h[sbpr_pkg::HeightW-1:0];
        peak_mem[col[sbpr_pkg::BandIdxW-1:0]]   = p[sbpr_pkg::HeightW-1:0];
        res.height = h[sbpr_pkg::HeightW-1:0];
        res.peak   = p[sbpr_pkg::HeightW-1:0];
      end
    end else begin
      col = int'(it.x) >> sbpr_pkg::BandWidthLog;
      h   = 0;
      p   = 0;
      if (col < sbpr_pkg::NumBands) begin
        h = int'(height_mem[col[sbpr_pkg::BandIdxW-1:0]]);
        p = int'(peak_mem[col[sbpr_pkg::BandIdxW-1:0]]);
      end
      row = int'(it.y);
      f   = int'($signed(it.fill));
      if ((row == sbpr_pkg::PanelSize - 1 || row == sbpr_pkg::PanelSize - 2) && f >= 0 &&
          int'(it.x) < f) begin
        res.pixel = sbpr_pkg::White565;
      end else if (p > 0 && row + p == base) begin
        res.pixel = sbpr_pkg::White565;
      end else if (row <= base && row + h > base) begin
        res.pixel = colour_565(bar_colour);
      end
      res.height = h[sbpr_pkg::HeightW-1:0];
      res.peak   = p[sbpr_pkg::HeightW-1:0];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bar_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < sbpr_pkg::NumBands; i++) begin
        height_mem[i] = '0;
        peak_mem[i]   = '0;
      end
      bar_colour = sbpr_pkg::BarRgbReset;
      result_q.delete();
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("result with no item pending, pixel %h", pixel_i));
        end else begin
          want = result_q.pop_front();
          if (pixel_i !== want.pixel)
            report_mismatch($sformatf("pixel got %h want %h", pixel_i, want.pixel));
          if (band_height_i !== want.height)
            report_mismatch($sformatf("height got %0d want %0d", band_height_i, want.height));
          if (band_peak_i !== want.peak)
            report_mismatch($sformatf("peak got %0d want %0d", band_peak_i, want.peak));
        end
      end
      if (start_i && !busy_i) begin
        render_item(item_i, want);
        result_q.push_back(want);
      end
      if (psel_i && penable_i && pready_i &&
          paddr_i[sbpr_pkg::ApbAddrW-1:2] == sbpr_pkg::RegBarRgb) begin
        if (pwrite_i) begin
          bar_colour = pwdata_i[sbpr_pkg::RgbW-1:0];
        end else if (prdata_i[sbpr_pkg::RgbW-1:0] !== bar_colour) begin
          report_mismatch($sformatf("bar colour read %h want %h",
                                    prdata_i[sbpr_pkg::RgbW-1:0], bar_colour));
        end
      end
      pending_o <= result_q.size();
    end
  end

endmodule

// File: tb/tb.sv
// testbench top for the spectrum bar peak renderer: stimulus, register writes and verdict
`timescale 1ns / 100ps
module tb;

  localparam int CycleLimit  = 200000;
  localparam int NumPhases   = 8;
  localparam int PhaseItems  = 228;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start_i;
  logic                            busy_o;
  sbpr_pkg::item_t                 cur_item;
  logic                            done_o;
  logic [sbpr_pkg::PixelW-1:0]     pixel_o;
  logic [sbpr_pkg::HeightW-1:0]    band_height_o;
  logic [sbpr_pkg::HeightW-1:0]    band_peak_o;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [sbpr_pkg::ApbAddrW-1:0]   paddr;
  logic [sbpr_pkg::ApbDataW-1:0]   pwdata;
  logic [sbpr_pkg::ApbDataW-1:0]   prdata;
  logic                            pready;
  int                              pending;
  int                              fail_count;

  int                              cycle_count = 0;
  int                              n_updates = 0;
  int                              n_queries = 0;
  int                              n_colours = 0;
  bit                              gaps_on;

  spectrum_bar_peak_renderer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (cur_item.req),
    .band_i       (cur_item.addr),
    .level_i      (cur_item.level),
    .x_i          (cur_item.x),
    .y_i          (cur_item.y),
    .fill_i       (cur_item.fill),
    .done_o       (done_o),
    .pixel_o      (pixel_o),
    .band_height_o(band_height_o),
    .band_peak_o  (band_peak_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  bar_pixel_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .item_i       (cur_item),
    .done_i       (done_o),
    .pixel_i      (pixel_o),
    .band_height_i(band_height_o),
    .band_peak_i  (band_peak_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles with %0d results pending", cycle_count, pending);
      $display("status: fail");
      $finish;
    end
  end

  function automatic sbpr_pkg::item_t update_item(input int band, input int lvl);
    sbpr_pkg::item_t it;
    it       = '0;
    it.req   = sbpr_pkg::REQ_UPDATE;
    it.addr  = band[sbpr_pkg::BandIdxW-1:0];
    it.level = lvl[sbpr_pkg::LevelW-1:0];
    it.x     = sbpr_pkg::CoordW'($urandom());
    it.y     = sbpr_pkg::CoordW'($urandom());
    it.fill  = sbpr_pkg::FillW'($urandom());
    return it;
  endfunction

  function automatic sbpr_pkg::item_t query_item(input int col, input int row, input int fill);
    sbpr_pkg::item_t it;
    it       = '0;
    it.req   = sbpr_pkg::REQ_QUERY;
    it.addr  = sbpr_pkg::BandIdxW'($urandom());
    it.level = sbpr_pkg::LevelW'($urandom());
    it.x     = col[sbpr_pkg::CoordW-1:0];
    it.y     = row[sbpr_pkg::CoordW-1:0];
    it.fill  = fill[sbpr_pkg::FillW-1:0];
    return it;
  endfunction

  function automatic sbpr_pkg::item_t random_update(input int band);
    int lvl;
    case ($urandom_range(0, 3))
      0: lvl = $urandom_range(0, 255);
      1: lvl = $urandom_range(56, 64);
      2: lvl = $urandom_range(0, 3);
      default: lvl = $urandom_range(0, 60);
    endcase
    return update_item(band, lvl);
  endfunction

  function automatic sbpr_pkg::item_t random_query(input int col);
    int row;
    int fill;
    case ($urandom_range(0, 3))
      0: row = $urandom_range(54, 63);
      1: row = $urandom_range(0, 12);
      default: row = $urandom_range(0, 63);
    endcase
    case ($urandom_range(0, 4))
      0: fill = -1;
      1: fill = $urandom_range(0, 255);
      2: fill = col + $urandom_range(0, 1);
      default: fill = $urandom_range(0, 64);
    endcase
    return query_item(col, row, fill);
  endfunction

  task automatic send_item(input sbpr_pkg::item_t it);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    cur_item <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (it.req == sbpr_pkg::REQ_UPDATE) n_updates++;
    else n_queries++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [sbpr_pkg::ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sbpr_pkg::RegBarRgb, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    logic [sbpr_pkg::RgbW-1:0] colour;
    int                        band;
    int                        phase_end;
    rst_ni   = 1'b0;
    start_i  = 1'b0;
    cur_item = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    gaps_on  = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners under the reset bar colour
    send_item(query_item(0, 60, -1));
    send_item(update_item(0, 255));
    send_item(update_item(15, 60));
    send_item(update_item(1, 61));
    send_item(update_item(2, 0));
    send_item(update_item(0, 10));
    send_item(query_item(0, 1, -1));
    send_item(query_item(1, 51, -1));
    send_item(query_item(2, 50, -1));
    send_item(query_item(3, 60, -1));
    send_item(query_item(63, 0, -1));
    send_item(query_item(63, 61, -1));
    send_item(query_item(5, 62, 6));
    send_item(query_item(6, 63, 6));
    send_item(query_item(63, 63, 64));
    send_item(query_item(0, 62, -1));
    send_item(query_item(0, 62, 0));
    send_item(query_item(10, 62, -128));
    send_item(query_item(10, 63, 127));
    send_item(update_item(3, 1));
    send_item(update_item(3, 0));
    send_item(query_item(12, 60, -1));
    send_item(update_item(3, 0));
    send_item(query_item(13, 60, 200));

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        0: colour = 24'h000000;
        1: colour = 24'hFFFFFF;
        2: colour = 24'h070307;
        3: colour = 24'hF8FCF8;
        6: colour = sbpr_pkg::BarRgbReset;
        default: colour = sbpr_pkg::RgbW'($urandom());
      endcase
      apb_access(1'b1, {8'($urandom()), colour});
      apb_access(1'b0, '0);
      n_colours++;
      gaps_on   = (ph != NumPhases - 1) && (ph % 3 != 2);
      phase_end = n_updates + n_queries + PhaseItems;
      while (n_updates + n_queries < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // one display frame: every band updated, then a scan of pixels
            for (int b = 0; b < sbpr_pkg::NumBands; b++) send_item(random_update(b));
            repeat ($urandom_range(4, 24)) send_item(random_query($urandom_range(0, 63)));
          end
          4, 5: begin
            // silence on one band so its peak falls toward zero
            band = $urandom_range(0, sbpr_pkg::NumBands - 1);
            repeat ($urandom_range(2, 8)) send_item(update_item(band, 0));
            repeat ($urandom_range(2, 6))
              send_item(random_query(band * 4 + $urandom_range(0, 3)));
          end
          default: begin
            if ($urandom_range(0, 1) == 0)
              send_item(random_update($urandom_range(0, sbpr_pkg::NumBands - 1)));
            else
              send_item(random_query($urandom_range(0, 63)));
          end
        endcase
      end
    end

    drain();
    $display("covered %0d band updates and %0d pixel queries over %0d bar colours",
             n_updates, n_queries, n_colours + 1);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
design/sbpr_pkg.sv
design/spectrum_bar_peak_renderer.sv
tb/bar_pixel_checker.sv
tb/tb.sv
